### src/lpta_pkg.sv
package lpta_pkg;

    // Field widths
    localparam int ID_W   = 32;
    localparam int TIME_W = 32;
    localparam int SLOT_W = 6;
    localparam int LIM_W  = 7;

    // Table size default and reset values
    localparam int              DEF_MAX_SLOTS = 64;
    localparam logic [ID_W-1:0] FIRST_ID      = 32'd100;
    localparam logic [LIM_W-1:0] LIMIT_RESET  = 7'd64;

    typedef enum logic {
        OP_ALLOC  = 1'b0,
        OP_ACCESS = 1'b1
    } t_opcode;

    // One table slot as stored in memory
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   page_id;
        logic [TIME_W-1:0] stamp;
    } t_slot_entry;

    // Summary of one pass over the table
    typedef struct packed {
        logic have_victim;
        logic have_free;
        logic hit;
    } t_scan_flags;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_EVICT_WR,
        ST_RESP
    } t_state;

endpackage

### src/lpta_in_if.sv
interface lpta_in_if import lpta_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [ID_W-1:0]   lookup_id;
    logic [TIME_W-1:0] now;

    modport source (output valid, output opcode, output lookup_id, output now, input ready);
    modport sink   (input valid, input opcode, input lookup_id, input now, output ready);
endinterface

### src/lpta_out_if.sv
interface lpta_out_if import lpta_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   new_id;
    logic              evicted;
    logic [ID_W-1:0]   evicted_id;

    modport source (output valid, output found, output slot, output new_id,
                    output evicted, output evicted_id, input ready);
    modport sink   (input valid, input found, input slot, input new_id,
                    input evicted, input evicted_id, output ready);
endinterface

### src/lpta_slot_mem.sv
module lpta_slot_mem import lpta_pkg::*; #(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS,
    parameter int AW        = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_slot_entry   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_slot_entry   o_rdata
);

    t_slot_entry r_mem [MAX_SLOTS];
    t_slot_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/lpta_scan.sv
module lpta_scan import lpta_pkg::*; #(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS,
    parameter int AW        = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_vld,
    input  logic [AW-1:0]   i_idx,
    input  t_slot_entry     i_entry,
    input  logic [ID_W-1:0] i_key,
    output t_scan_flags     o_flags,
    output logic [AW-1:0]   o_vic_idx,
    output logic [ID_W-1:0] o_vic_id,
    output logic [AW-1:0]   o_free_idx,
    output logic [AW-1:0]   o_hit_idx
);

    t_scan_flags       r_flags;
    logic [AW-1:0]     r_vic_idx;
    logic [ID_W-1:0]   r_vic_id;
    logic [TIME_W-1:0] r_vic_time;
    logic [AW-1:0]     r_free_idx;
    logic [AW-1:0]     r_hit_idx;

    logic older;
    logic take_victim;
    logic take_free;
    logic take_hit;

    // Oldest time wins, equal times go to the smaller id, equal both keep the lower slot
    always_comb begin
        older = (i_entry.stamp < r_vic_time) ||
                ((i_entry.stamp == r_vic_time) && (i_entry.page_id < r_vic_id));
        take_victim = i_vld && i_entry.valid && (!r_flags.have_victim || older);
        take_free   = i_vld && !i_entry.valid && !r_flags.have_free;
        take_hit    = i_vld && i_entry.valid && !r_flags.hit && (i_entry.page_id == i_key);
    end

    // Track flags; clear at the start of each pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_flags <= '0;
        end else begin
            if (take_victim) r_flags.have_victim <= 1'b1;
            if (take_free)   r_flags.have_free   <= 1'b1;
            if (take_hit)    r_flags.hit         <= 1'b1;
        end
    end

    // Hold candidate slots and their keys
    always_ff @(posedge i_clk) begin
        if (take_victim) begin
            r_vic_idx  <= i_idx;
            r_vic_id   <= i_entry.page_id;
            r_vic_time <= i_entry.stamp;
        end
        if (take_free) begin
            r_free_idx <= i_idx;
        end
        if (take_hit) begin
            r_hit_idx <= i_idx;
        end
    end

    assign o_flags    = r_flags;
    assign o_vic_idx  = r_vic_idx;
    assign o_vic_id   = r_vic_id;
    assign o_free_idx = r_free_idx;
    assign o_hit_idx  = r_hit_idx;

endmodule

### src/lpta_ctrl.sv
module lpta_ctrl import lpta_pkg::*; #(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS,
    parameter int AW        = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LIM_W-1:0] i_cfg_data,
    lpta_in_if.sink          i_in,
    lpta_out_if.source       o_out,
    // memory side
    output logic             o_mem_we,
    output logic [AW-1:0]    o_mem_waddr,
    output t_slot_entry      o_mem_wdata,
    output logic             o_mem_re,
    output logic [AW-1:0]    o_mem_raddr,
    // scan side
    output logic             o_scan_start,
    output logic             o_scan_vld,
    output logic [AW-1:0]    o_scan_idx,
    output logic [ID_W-1:0]  o_scan_key,
    input  t_scan_flags      i_flags,
    input  logic [AW-1:0]    i_vic_idx,
    input  logic [ID_W-1:0]  i_vic_id,
    input  logic [AW-1:0]    i_free_idx,
    input  logic [AW-1:0]    i_hit_idx
);

    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int LW = (CW > LIM_W) ? CW : LIM_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_SLOTS - 1);
    localparam logic [CW-1:0] SLOT_CNT = CW'(MAX_SLOTS);
    localparam logic [LW-1:0] LIM_MAX  = LW'(MAX_SLOTS);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt;
    logic              r_pend;
    logic [AW-1:0]     r_pend_idx;
    logic              r_op;
    logic [ID_W-1:0]   r_key;
    logic [TIME_W-1:0] r_now;
    logic [LIM_W-1:0]  r_page_limit;
    logic [CW-1:0]     r_used, n_used;
    logic [ID_W-1:0]   r_next_id;

    // result staging
    logic              r_res_found;
    logic [SLOT_W-1:0] r_res_slot;
    logic [ID_W-1:0]   r_res_new_id;
    logic              r_res_evicted;
    logic [ID_W-1:0]   r_res_evicted_id;

    // output register
    logic              r_out_vld;
    logic              r_out_found;
    logic [SLOT_W-1:0] r_out_slot;
    logic [ID_W-1:0]   r_out_new_id;
    logic              r_out_evicted;
    logic [ID_W-1:0]   r_out_evicted_id;

    logic          in_fire;
    logic          issue;
    logic          scan_last;
    logic          out_free;
    logic [LW-1:0] limit_ext;
    logic [LW-1:0] eff_lim;
    logic          do_evict;
    logic          do_place;
    logic          need_inval;
    logic [AW-1:0] place_idx;
    logic          is_alloc;
    t_slot_entry   new_entry;
    t_slot_entry   hit_entry;

    assign is_alloc  = (r_op == OP_ALLOC);
    assign in_fire   = i_in.valid && i_in.ready;
    assign issue     = (r_state == ST_SCAN) && (r_cnt < SLOT_CNT);
    assign scan_last = r_pend && (r_pend_idx == LAST_IDX);
    assign out_free  = !r_out_vld || o_out.ready;

    // Eviction decision and placement slot
    always_comb begin
        limit_ext = LW'(r_page_limit);
        if (limit_ext == '0) begin
            eff_lim = LW'(1);
        end else if (limit_ext > LIM_MAX) begin
            eff_lim = LIM_MAX;
        end else begin
            eff_lim = limit_ext;
        end
        do_evict = (LW'(r_used) >= eff_lim) && i_flags.have_victim;
        do_place = do_evict || i_flags.have_free;
        if (do_evict) begin
            place_idx = (i_flags.have_free && (i_free_idx < i_vic_idx)) ? i_free_idx
                                                                        : i_vic_idx;
        end else begin
            place_idx = i_free_idx;
        end
        need_inval = do_evict && (place_idx != i_vic_idx);
        n_used = r_used - CW'(do_evict) + CW'(do_place);
        new_entry = '{valid: 1'b1, page_id: r_next_id, stamp: '0};
        hit_entry = '{valid: 1'b1, page_id: r_key, stamp: r_now};
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_cnt[AW-1:0] == LAST_IDX) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_fire) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_last) n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                n_state = (is_alloc && need_inval) ? ST_EVICT_WR : ST_RESP;
            end
            ST_EVICT_WR: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Outputs: memory ports, scan control, input ready
    always_comb begin
        o_mem_we     = 1'b0;
        o_mem_waddr  = '0;
        o_mem_wdata  = '0;
        o_mem_re     = issue;
        o_mem_raddr  = r_cnt[AW-1:0];
        o_scan_start = in_fire;
        i_in.ready   = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_cnt[AW-1:0];
            end
            ST_IDLE: begin
                i_in.ready = 1'b1;
            end
            ST_COMMIT: begin
                if (!is_alloc && i_flags.hit) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = i_hit_idx;
                    o_mem_wdata = hit_entry;
                end else if (is_alloc && do_place) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = place_idx;
                    o_mem_wdata = new_entry;
                end
            end
            ST_EVICT_WR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = i_vic_idx;
            end
            default: begin
            end
        endcase
    end

    assign o_scan_vld = r_pend;
    assign o_scan_idx = r_pend_idx;
    assign o_scan_key = r_key;

    // State, counters and table bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_cnt        <= '0;
            r_pend       <= 1'b0;
            r_page_limit <= LIMIT_RESET;
            r_used       <= '0;
            r_next_id    <= FIRST_ID;
        end else begin
            r_state <= n_state;
            r_pend  <= issue;
            if (i_cfg_we) begin
                r_page_limit <= i_cfg_data;
            end
            if (r_state == ST_CLEAR) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (in_fire) begin
                r_cnt <= '0;
            end else if (issue) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if ((r_state == ST_COMMIT) && is_alloc) begin
                r_used    <= n_used;
                r_next_id <= r_next_id + ID_W'(1);
            end
        end
    end

    // Capture the input word and stage the result
    always_ff @(posedge i_clk) begin
        r_pend_idx <= r_cnt[AW-1:0];
        if (in_fire) begin
            r_op  <= i_in.opcode;
            r_key <= i_in.lookup_id;
            r_now <= i_in.now;
        end
        if (r_state == ST_COMMIT) begin
            if (is_alloc) begin
                r_res_found      <= 1'b1;
                r_res_slot       <= do_place ? SLOT_W'(place_idx) : '0;
                r_res_new_id     <= r_next_id;
                r_res_evicted    <= do_evict;
                r_res_evicted_id <= do_evict ? i_vic_id : '0;
            end else begin
                r_res_found      <= i_flags.hit;
                r_res_slot       <= i_flags.hit ? SLOT_W'(i_hit_idx) : '0;
                r_res_new_id     <= '0;
                r_res_evicted    <= 1'b0;
                r_res_evicted_id <= '0;
            end
        end
    end

    // Output register: load when free, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == ST_RESP) && out_free) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_RESP) && out_free) begin
            r_out_found      <= r_res_found;
            r_out_slot       <= r_res_slot;
            r_out_new_id     <= r_res_new_id;
            r_out_evicted    <= r_res_evicted;
            r_out_evicted_id <= r_res_evicted_id;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.found      = r_out_found;
    assign o_out.slot       = r_out_slot;
    assign o_out.new_id     = r_out_new_id;
    assign o_out.evicted    = r_out_evicted;
    assign o_out.evicted_id = r_out_evicted_id;

    // The page count never exceeds the table
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= SLOT_CNT)
        else $error("page count above table size");

    // No table write while waiting for a word
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !o_mem_we)
        else $error("table written while idle");

    // An accepted word always starts a pass
    a_fire_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_SCAN))
        else $error("accepted word did not start a pass");

    // Invalidation only targets a found victim
    a_evict_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVICT_WR) |-> i_flags.have_victim)
        else $error("invalidation without a victim");

    // Every allocation advances the id counter by one
    a_next_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_COMMIT) && is_alloc) |=> (r_next_id == $past(r_next_id) + ID_W'(1)))
        else $error("page id counter did not advance");

endmodule

### src/lru_page_table_allocator_top.sv
// Page table with least-recently-accessed replacement.
//
// Input channel i_in carries one word per request: opcode selects allocate or
// access, lookup_id is the page to find on access, now is the stamp written on
// a hit. Output channel o_out returns exactly one word per request, in order.
// The user writes the page limit via i_cfg_we / i_cfg_data only while idle,
// not enforced by the block. Zero acts as one, above MAX_SLOTS as MAX_SLOTS.
//
// Every request makes one full pass over the slot memory, one slot per cycle
// on its single read port. A commit step follows the pass, then a write that
// invalidates the victim when an allocate evicts into a different slot than
// the one it fills, and then the result is loaded into the output register.
// A new request is taken only after the last result has been loaded there.
//
// After reset the block sweeps the memory to mark all slots free, with i_in.ready
// low. A stalled receiver holds the result in the output register; the next
// request is still accepted and worked on, and waits only before its own
// result is loaded.
module lru_page_table_allocator_top import lpta_pkg::*; #(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [LIM_W-1:0] i_cfg_data,
    lpta_in_if.sink          i_in,
    lpta_out_if.source       o_out
);

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    t_slot_entry     mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    t_slot_entry     mem_rdata;

    logic            scan_start;
    logic            scan_vld;
    logic [AW-1:0]   scan_idx;
    logic [ID_W-1:0] scan_key;
    t_scan_flags     scan_flags;
    logic [AW-1:0]   vic_idx;
    logic [ID_W-1:0] vic_id;
    logic [AW-1:0]   free_idx;
    logic [AW-1:0]   hit_idx;

    // Slot storage
    lpta_slot_mem #(
        .MAX_SLOTS (MAX_SLOTS),
        .AW        (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Victim, free slot and hit tracking over the read stream
    lpta_scan #(
        .MAX_SLOTS (MAX_SLOTS),
        .AW        (AW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (scan_start),
        .i_vld      (scan_vld),
        .i_idx      (scan_idx),
        .i_entry    (mem_rdata),
        .i_key      (scan_key),
        .o_flags    (scan_flags),
        .o_vic_idx  (vic_idx),
        .o_vic_id   (vic_id),
        .o_free_idx (free_idx),
        .o_hit_idx  (hit_idx)
    );

    // Sequencer, bookkeeping and output register
    lpta_ctrl #(
        .MAX_SLOTS (MAX_SLOTS),
        .AW        (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in         (i_in),
        .o_out        (o_out),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_re     (mem_re),
        .o_mem_raddr  (mem_raddr),
        .o_scan_start (scan_start),
        .o_scan_vld   (scan_vld),
        .o_scan_idx   (scan_idx),
        .o_scan_key   (scan_key),
        .i_flags      (scan_flags),
        .i_vic_idx    (vic_idx),
        .i_vic_id     (vic_id),
        .i_free_idx   (free_idx),
        .i_hit_idx    (hit_idx)
    );

endmodule
